/* rtl/htwd_pkg.sv */
package htwd_pkg;

  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int CODE_W     = 8;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int NODE_SLOTS_DEF = 512;
  localparam int CMD_DEPTH_DEF  = 2;
  localparam int RES_DEPTH_DEF  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT_NODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_TOTAL = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef enum logic [1:0] {
    K_LOAD,
    K_DROP,
    K_DECODE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  addr;
    node_t             node;
    logic [CODE_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done;
  } res_t;

endpackage

/* rtl/htwd_ram.sv */
module htwd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/htwd_fifo.sv */
module htwd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/htwd_front.sv */
module htwd_front #(
  parameter int NODE_SLOTS = htwd_pkg::NODE_SLOTS_DEF,
  parameter int CMD_DEPTH  = htwd_pkg::CMD_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_func,
  input  logic [htwd_pkg::IDX_W-1:0]    in_node_address,
  input  logic                          in_node_is_leaf,
  input  logic [htwd_pkg::SYM_W-1:0]    in_node_symbol,
  input  logic [htwd_pkg::IDX_W-1:0]    in_left_index,
  input  logic [htwd_pkg::IDX_W-1:0]    in_right_index,
  input  logic [htwd_pkg::CODE_W-1:0]   in_code_byte,
  output htwd_pkg::cmd_t                cmd,
  output logic                          cmd_valid,
  input  logic                          cmd_pop
);

  htwd_pkg::cmd_t cmd_in;
  logic           cmd_empty;
  logic           addr_ok;

  assign addr_ok = int'(in_node_address) < NODE_SLOTS;

  always_comb begin
    cmd_in.addr       = in_node_address;
    cmd_in.node.leaf  = in_node_is_leaf;
    cmd_in.node.sym   = in_node_symbol;
    cmd_in.node.left  = in_left_index;
    cmd_in.node.right = in_right_index;
    cmd_in.code       = in_code_byte;
    if (in_func) begin
      cmd_in.kind = htwd_pkg::K_DECODE;
    end else if (addr_ok) begin
      cmd_in.kind = htwd_pkg::K_LOAD;
    end else begin
      cmd_in.kind = htwd_pkg::K_DROP;
    end
  end

  htwd_fifo #(
    .WIDTH ($bits(htwd_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

/* rtl/htwd_back.sv */
module htwd_back #(
  parameter int NODE_SLOTS = htwd_pkg::NODE_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  htwd_pkg::cmd_t                    cmd,
  input  logic                              cmd_valid,
  output logic                              cmd_pop,
  input  logic                              cfg_valid,
  input  logic [htwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htwd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              res_push,
  output htwd_pkg::res_t                    res,
  input  logic                              res_full
);

  localparam int AW = $clog2(NODE_SLOTS);
  localparam int BW = $clog2(htwd_pkg::CODE_W + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROOT,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t                          state_r, state_nxt;
  logic [htwd_pkg::IDX_W-1:0]      root_r, root_nxt;
  logic [htwd_pkg::CNT_W-1:0]      total_r, total_nxt;
  logic [htwd_pkg::IDX_W-1:0]      cursor_r, cursor_nxt;
  logic [htwd_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                            fin_r, fin_nxt;
  logic [htwd_pkg::CODE_W-1:0]     code_r, code_nxt;
  logic [BW-1:0]                   bits_r, bits_nxt;
  logic                            first_r, first_nxt;
  htwd_pkg::node_t                 cur_r, cur_nxt;
  htwd_pkg::node_t                 rootn_r, rootn_nxt;
  logic [htwd_pkg::SYM_W-1:0]      hold_sym_r, hold_sym_nxt;
  logic                            hold_done_r, hold_done_nxt;
  logic                            hold_v_r, hold_v_nxt;
  logic                            oor_r, oor_nxt;

  logic [htwd_pkg::IDX_W-1:0]      raddr;
  logic                            we;
  logic [$bits(htwd_pkg::node_t)-1:0] rdata_raw;
  htwd_pkg::node_t                 nxt;
  htwd_pkg::node_t                 node_here;
  logic [htwd_pkg::IDX_W-1:0]      nidx;
  logic [htwd_pkg::CNT_W-1:0]      cnt_inc;
  logic                            leaf_hit, done_hit, need_push, stall;

  htwd_ram #(
    .WIDTH ($bits(htwd_pkg::node_t)),
    .DEPTH (NODE_SLOTS)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(cmd.addr)),
    .wdata (cmd.node),
    .raddr (AW'(raddr)),
    .rdata (rdata_raw)
  );

  // out-of-range indices read as an all-zero node
  assign nxt       = oor_r ? '0 : htwd_pkg::node_t'(rdata_raw);
  assign leaf_hit  = (state_r == S_WALK) && !first_r && nxt.leaf;
  assign cnt_inc   = count_r + 1'b1;
  assign done_hit  = leaf_hit && (cnt_inc == total_r);
  assign need_push = leaf_hit && hold_v_r;
  assign stall     = need_push && res_full;
  assign node_here = first_r ? cur_r : (leaf_hit ? rootn_r : nxt);
  assign nidx      = code_r[htwd_pkg::CODE_W-1] ? node_here.left : node_here.right;

  always_comb begin
    state_nxt     = state_r;
    root_nxt      = root_r;
    total_nxt     = total_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    fin_nxt       = fin_r;
    code_nxt      = code_r;
    bits_nxt      = bits_r;
    first_nxt     = first_r;
    cur_nxt       = cur_r;
    rootn_nxt     = rootn_r;
    hold_sym_nxt  = hold_sym_r;
    hold_done_nxt = hold_done_r;
    hold_v_nxt    = hold_v_r;
    raddr         = cursor_r;
    we            = 1'b0;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res           = '0;

    if (cfg_valid) begin
      case (cfg_index)
        htwd_pkg::REG_ROOT_NODE: begin
          root_nxt   = cfg_data[htwd_pkg::IDX_W-1:0];
          cursor_nxt = cfg_data[htwd_pkg::IDX_W-1:0];
        end
        htwd_pkg::REG_SYMBOL_TOTAL: begin
          total_nxt = cfg_data[htwd_pkg::CNT_W-1:0];
        end
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && !cfg_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            htwd_pkg::K_LOAD: we = 1'b1;
            htwd_pkg::K_DECODE: begin
              if (!fin_r && (count_r < total_r)) begin
                code_nxt  = cmd.code;
                bits_nxt  = '0;
                state_nxt = S_ROOT;
              end
            end
            default: ;
          endcase
        end
      end

      S_ROOT: begin
        raddr     = root_r;
        cur_nxt   = nxt;
        first_nxt = 1'b1;
        state_nxt = S_WALK;
      end

      S_WALK: begin
        if (!stall) begin
          if (first_r) begin
            rootn_nxt = nxt;
            first_nxt = 1'b0;
          end
          if (need_push) begin
            res_push    = 1'b1;
            res.symbol  = hold_sym_r;
            res.last    = 1'b0;
            res.done    = hold_done_r;
          end
          if (leaf_hit) begin
            hold_sym_nxt  = nxt.sym;
            hold_done_nxt = done_hit;
            hold_v_nxt    = 1'b1;
            count_nxt     = cnt_inc;
            cursor_nxt    = root_r;
            if (done_hit) begin
              fin_nxt = 1'b1;
            end
          end
          if ((bits_r != BW'(htwd_pkg::CODE_W)) && !done_hit) begin
            raddr      = nidx;
            cursor_nxt = nidx;
            code_nxt   = code_r << 1;
            bits_nxt   = bits_r + 1'b1;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (!res_full) begin
          res_push   = 1'b1;
          res.symbol = hold_sym_r;
          res.last   = 1'b1;
          res.done   = hold_done_r;
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    oor_nxt = !(int'(raddr) < NODE_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      root_r   <= '0;
      total_r  <= '0;
      cursor_r <= '0;
      count_r  <= '0;
      fin_r    <= 1'b0;
      hold_v_r <= 1'b0;
      first_r  <= 1'b0;
      bits_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      root_r   <= root_nxt;
      total_r  <= total_nxt;
      cursor_r <= cursor_nxt;
      count_r  <= count_nxt;
      fin_r    <= fin_nxt;
      hold_v_r <= hold_v_nxt;
      first_r  <= first_nxt;
      bits_r   <= bits_nxt;
    end
    code_r      <= code_nxt;
    cur_r       <= cur_nxt;
    rootn_r     <= rootn_nxt;
    hold_sym_r  <= hold_sym_nxt;
    hold_done_r <= hold_done_nxt;
    oor_r       <= oor_nxt;
  end

endmodule

/* rtl/huffman_tree_walk_decoder_unit.sv */
// Huffman tree-walk decoder.
// Input channel (in_push / in_full): one beat is either a node load
// (in_func = 0), writing an in-range node-table entry, or a code byte
// (in_func = 1), decoded MSB first; bit 1 takes the left child, 0 the right.
// Result channel (out_empty / out_pop): one beat per decoded symbol, with
// out_last_of_item on the last symbol of a code byte and out_stream_done on
// the symbol that reaches the configured total; later bytes yield nothing.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 root node
// (also resets the walk cursor), index 1 symbol total. Write while idle.
// Walker: a load is one node-table write. A code byte is walked with one
// node-table read per code bit on the single read port, plus reads of the
// cursor and root nodes and a closing flush step for the held last symbol;
// the walker takes no new command until the byte is done. A symbol is held
// until the next leaf or the flush step, and then enters the result queue.
// A small command queue decouples input from the walker; a result queue
// decouples it from the receiver. When the receiver stalls and the result
// queue fills, the walker pauses on the current bit, then the command queue
// fills and in_full rises. Reset clears queues, state, root, total, cursor
// and count; node table contents are undefined until loaded.
module huffman_tree_walk_decoder_unit #(
  parameter int NODE_SLOTS = htwd_pkg::NODE_SLOTS_DEF,
  parameter int CMD_DEPTH  = htwd_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH  = htwd_pkg::RES_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_func,
  input  logic [htwd_pkg::IDX_W-1:0]        in_node_address,
  input  logic                              in_node_is_leaf,
  input  logic [htwd_pkg::SYM_W-1:0]        in_node_symbol,
  input  logic [htwd_pkg::IDX_W-1:0]        in_left_index,
  input  logic [htwd_pkg::IDX_W-1:0]        in_right_index,
  input  logic [htwd_pkg::CODE_W-1:0]       in_code_byte,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [htwd_pkg::SYM_W-1:0]        out_symbol,
  output logic                              out_last_of_item,
  output logic                              out_stream_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [htwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htwd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  htwd_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;
  htwd_pkg::res_t res_in;
  htwd_pkg::res_t res_out;
  logic           res_push;
  logic           res_full;

  assign cfg_ready = 1'b1;

  htwd_front #(
    .NODE_SLOTS (NODE_SLOTS),
    .CMD_DEPTH  (CMD_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_node_address (in_node_address),
    .in_node_is_leaf (in_node_is_leaf),
    .in_node_symbol  (in_node_symbol),
    .in_left_index   (in_left_index),
    .in_right_index  (in_right_index),
    .in_code_byte    (in_code_byte),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop)
  );

  htwd_back #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  htwd_fifo #(
    .WIDTH ($bits(htwd_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_symbol       = res_out.symbol;
  assign out_last_of_item = res_out.last;
  assign out_stream_done  = res_out.done;

endmodule

/* rtl/htwd_checker.sv */
module htwd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_push,
  input logic                              in_full,
  input logic                              in_func,
  input logic [htwd_pkg::IDX_W-1:0]        in_node_address,
  input logic                              in_node_is_leaf,
  input logic [htwd_pkg::SYM_W-1:0]        in_node_symbol,
  input logic [htwd_pkg::IDX_W-1:0]        in_left_index,
  input logic [htwd_pkg::IDX_W-1:0]        in_right_index,
  input logic [htwd_pkg::CODE_W-1:0]       in_code_byte,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic [htwd_pkg::SYM_W-1:0]        out_symbol,
  input logic                              out_last_of_item,
  input logic                              out_stream_done,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [htwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [htwd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // stream end always closes a code byte
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_stream_done |-> out_last_of_item)
    else $error("stream_done without last_of_item");

  a_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_symbol) &&
      $stable(out_last_of_item) && $stable(out_stream_done))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind huffman_tree_walk_decoder_unit htwd_checker u_htwd_checker (.*);
